// ----- rtl/clustering_f_measure_assert.svh -----
// assertion macros shared by the checker
`ifndef CLUSTERING_F_MEASURE_ASSERT_SVH
`define CLUSTERING_F_MEASURE_ASSERT_SVH

// same-cycle implication, off during reset
`define CLFM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CLFM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked during reset
`define CLFM_ASSERT_ALWAYS_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/clfm_pkg.sv -----
package clfm_pkg;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_CMP,
        S_COL_LOAD,
        S_COL_DIV,
        S_TERM,
        S_ACC,
        S_TAB_LOAD,
        S_TAB_DIV,
        S_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic prod;
        logic cmp;
        logic div_col_start;
        logic div_tab_start;
        logic div_step;
        logic term;
        logic acc;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// ----- rtl/clustering_f_measure.sv -----
// a plain cell runs the product and compare steps; a column end also runs the
// bit-serial divider for the column score, then the weighted-term and accumulate steps
// a table end runs that divider twice, for the column score and then for the final
// quotient; a new request is taken only once the block is back in idle
// reset: synchronous active low; clears best score, weighted sum, controller and
// output valid, and sets total_items to 1
module clustering_f_measure import clfm_pkg::*; #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COUNT_BITS-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COUNT_BITS-1:0] i_cell_count,
    input  logic [COUNT_BITS-1:0] i_row_total,
    input  logic [COUNT_BITS-1:0] i_col_total,
    input  logic                  i_column_end,
    input  logic                  i_table_end,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FRAC_BITS:0]    o_f_measure
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing
    clfm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_column_end (i_column_end),
        .i_table_end  (i_table_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    // arithmetic and state
    clfm_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cell_count (i_cell_count),
        .i_row_total  (i_row_total),
        .i_col_total  (i_col_total),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_f_measure  (o_f_measure)
    );

endmodule

// ----- rtl/clfm_datapath.sv -----
module clfm_datapath import clfm_pkg::*; #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COUNT_BITS-1:0] i_cfg_wdata,
    input  logic [COUNT_BITS-1:0] i_cell_count,
    input  logic [COUNT_BITS-1:0] i_row_total,
    input  logic [COUNT_BITS-1:0] i_col_total,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [FRAC_BITS:0]    o_f_measure
);

    localparam int NW = COUNT_BITS + 1;
    localparam int PW = 2 * NW;
    localparam int SW = COUNT_BITS + FRAC_BITS;
    localparam int DW = SW + 1;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] r_row;
    logic [COUNT_BITS-1:0] r_col;
    logic [NW-1:0]         r_best_num;
    logic [NW-1:0]         r_best_den;
    logic [SW-1:0]         r_sum;
    logic [PW-1:0]         r_p1;
    logic [PW-1:0]         r_p2;
    logic [NW-1:0]         r_rem;
    logic [DW-1:0]         r_dvd;
    logic [NW-1:0]         r_dvs;
    logic [CW-1:0]         r_div_cnt;
    logic [DW-1:0]         r_term;
    logic [FRAC_BITS:0]    r_f;

    logic [NW-1:0]      w_num;
    logic [NW-1:0]      w_den;
    logic [NW-1:0]      w_num_c;
    logic               w_scored;
    logic [PW-1:0]      w_prod1;
    logic [PW-1:0]      w_prod2;
    logic [NW:0]        w_rs;
    logic               w_ge;
    logic [NW:0]        w_diff;
    logic [FRAC_BITS:0] w_q_cap;
    logic [DW-1:0]      w_acc;

    // cell score as a clamped fraction
    assign w_num    = {r_count, 1'b0};
    assign w_den    = {1'b0, r_row} + {1'b0, r_col};
    assign w_num_c  = (w_num > w_den) ? w_den : w_num;
    assign w_scored = (r_count != '0) && (w_den != '0);

    // cross products for the compare
    assign w_prod1 = PW'(w_num_c) * PW'(r_best_den);
    assign w_prod2 = PW'(r_best_num) * PW'(w_den);

    // one restoring division step
    assign w_rs   = {r_rem, r_dvd[DW-1]};
    assign w_ge   = (w_rs >= {1'b0, r_dvs});
    assign w_diff = w_rs - {1'b0, r_dvs};

    // quotient capped at one
    assign w_q_cap = (r_dvd > ONE_Q) ? ONE_Q[FRAC_BITS:0] : r_dvd[FRAC_BITS:0];

    // saturating accumulate
    assign w_acc = {1'b0, r_sum} + r_term;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= COUNT_BITS'(1);
        end else if (i_cfg_we) begin
            r_total <= i_cfg_wdata;
        end
    end

    // input holding registers and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= i_cell_count;
            r_row   <= i_row_total;
            r_col   <= i_col_total;
        end
        if (i_cmd.prod) begin
            r_p1 <= w_prod1;
            r_p2 <= w_prod2;
        end
        if (i_cmd.term) begin
            r_term <= DW'(w_q_cap * r_col);
        end
        if (i_cmd.out_load) begin
            if (r_total == '0) begin
                r_f <= '0;
            end else begin
                r_f <= w_q_cap;
            end
        end
    end

    // best score of the current column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_num <= '0;
            r_best_den <= NW'(1);
        end else if (i_cmd.cmp && w_scored && (r_p1 > r_p2)) begin
            r_best_num <= w_num_c;
            r_best_den <= w_den;
        end else if (i_cmd.acc) begin
            r_best_num <= '0;
            r_best_den <= NW'(1);
        end
    end

    // running weighted sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= w_acc[SW] ? '1 : w_acc[SW-1:0];
        end else if (i_cmd.out_load) begin
            r_sum <= '0;
        end
    end

    // shared iterative divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_col_start || i_cmd.div_tab_start) begin
            r_div_cnt <= CW'(DW);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_col_start) begin
            r_dvd <= {r_best_num, {FRAC_BITS{1'b0}}};
            r_dvs <= r_best_den;
            r_rem <= '0;
        end else if (i_cmd.div_tab_start) begin
            r_dvd <= {1'b0, r_sum};
            r_dvs <= {1'b0, r_total};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[NW-1:0] : w_rs[NW-1:0];
            r_dvd <= {r_dvd[DW-2:0], w_ge};
        end
    end

    assign o_status.div_done = (r_div_cnt == '0);
    assign o_f_measure       = r_f;

endmodule

// ----- rtl/clfm_ctrl.sv -----
module clfm_ctrl import clfm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic    i_column_end,
    input  logic    i_table_end,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_col_end;
    logic   r_tab_end;
    logic   r_out_valid;
    logic   w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // end flags of the request in progress
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col_end <= i_column_end;
            r_tab_end <= i_table_end;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = (r_col_end || r_tab_end) ? S_COL_LOAD : S_IDLE;
            end
            S_COL_LOAD: begin
                o_cmd.div_col_start = 1'b1;
                n_state             = S_COL_DIV;
            end
            S_COL_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_TERM;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = r_tab_end ? S_TAB_LOAD : S_IDLE;
            end
            S_TAB_LOAD: begin
                o_cmd.div_tab_start = 1'b1;
                n_state             = S_TAB_DIV;
            end
            S_TAB_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/clfm_checker.sv -----
`include "clustering_f_measure_assert.svh"

module clfm_checker #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [COUNT_BITS-1:0] i_cfg_wdata,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [COUNT_BITS-1:0] i_cell_count,
    input logic [COUNT_BITS-1:0] i_row_total,
    input logic [COUNT_BITS-1:0] i_col_total,
    input logic                  i_column_end,
    input logic                  i_table_end,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [FRAC_BITS:0]    o_f_measure
);

    localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // a stalled result holds
    `CLFM_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_f_measure), "result changed while stalled")

    // the result never exceeds one
    `CLFM_ASSERT_IMP(a_out_range, o_valid, o_f_measure <= ONE_Q, "f-measure above one")

    // an accepted request keeps the block busy for the next cycle
    `CLFM_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready right after accept")

    // reset leaves no result pending
    `CLFM_ASSERT_ALWAYS_NXT(a_reset_clear, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind clustering_f_measure clfm_checker #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_clfm_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int          CNT_W         = 16;
    localparam int          FRAC_W        = 16;
    localparam logic [16:0] FM_ONE        = 17'd65536;
    localparam longint unsigned SUM_SAT   = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned ITEMS_PER_PHASE = 550;
    localparam int unsigned BATCHES       = 5;
    localparam int unsigned QUIET_CYCLES  = 100;
    localparam int unsigned DRAIN_LIMIT   = 200000;
    localparam int unsigned LONG_HOLD     = 1200;

    // one cell request
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             col_end;
        logic             tab_end;
    } cell_req_t;

    typedef enum bit {ROW_CELL, ROW_CFG} row_kind_t;

    // directed row: either a cell request or a total_items write
    typedef struct packed {
        row_kind_t        kind;
        logic [CNT_W-1:0] cfg_total;
        cell_req_t        req;
        bit               typed;
        logic [FRAC_W:0]  fm;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CNT_W-1:0]      i_cfg_wdata  = '0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [CNT_W-1:0]      i_cell_count = '0;
    logic [CNT_W-1:0]      i_row_total  = '0;
    logic [CNT_W-1:0]      i_col_total  = '0;
    logic                  i_column_end = 1'b0;
    logic                  i_table_end  = 1'b0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [FRAC_W:0]       o_f_measure;

    // predictor state, reset values
    logic [CNT_W-1:0]      total_items = 16'd1;
    logic [CNT_W:0]        best_num    = '0;
    logic [CNT_W:0]        best_den    = 17'd1;
    longint unsigned       weighted    = 0;

    logic [FRAC_W:0]       fm_pending [$];
    logic [FRAC_W:0]       want_fm;
    int unsigned           n_errors     = 0;
    int unsigned           n_cells_sent = 0;
    int unsigned           tx_idle_pct  = 0;
    int unsigned           rx_idle_pct  = 0;
    bit                    hold_armed   = 1'b0;
    bit                    hold_taken   = 1'b0;
    int unsigned           hold_left    = 0;

    int unsigned           tx_pct_by_phase [3] = '{8, 65, 0};
    int unsigned           rx_pct_by_phase [3] = '{65, 8, 0};

    // directed table: extremes, flag combinations and the special cases
    dir_row_t dir_rows [18] = '{
        // table end alone on an empty column
        '{ROW_CELL, 16'd0, '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b1, 17'd0},
        // perfect cell with reset total of one, result capped at one
        '{ROW_CELL, 16'd0, '{16'd5, 16'd5, 16'd5, 1'b0, 1'b1}, 1'b1, FM_ONE},
        '{ROW_CFG, 16'd0, '0, 1'b0, 17'd0},
        // zero item total
        '{ROW_CELL, 16'd0, '{16'd3, 16'd4, 16'd4, 1'b0, 1'b1}, 1'b1, 17'd0},
        '{ROW_CFG, 16'd65535, '0, 1'b0, 17'd0},
        // all fields at max, both flags
        '{ROW_CELL, 16'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1, FM_ONE},
        // two max columns saturate the sum
        '{ROW_CELL, 16'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}, 1'b0, 17'd0},
        '{ROW_CELL, 16'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}, 1'b1, FM_ONE},
        '{ROW_CFG, 16'd100, '0, 1'b0, 17'd0},
        // zero cell, zero totals, score above one
        '{ROW_CELL, 16'd0, '{16'd0, 16'd10, 16'd10, 1'b0, 1'b0}, 1'b0, 17'd0},
        '{ROW_CELL, 16'd0, '{16'd7, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, 17'd0},
        '{ROW_CELL, 16'd0, '{16'd9, 16'd4, 16'd6, 1'b0, 1'b0}, 1'b0, 17'd0},
        '{ROW_CELL, 16'd0, '{16'd3, 16'd10, 16'd20, 1'b1, 1'b0}, 1'b0, 17'd0},
        // tie keeps the first, then a lower score
        '{ROW_CELL, 16'd0, '{16'd2, 16'd6, 16'd10, 1'b0, 1'b0}, 1'b0, 17'd0},
        '{ROW_CELL, 16'd0, '{16'd4, 16'd12, 16'd20, 1'b0, 1'b0}, 1'b0, 17'd0},
        '{ROW_CELL, 16'd0, '{16'd1, 16'd9, 16'd7, 1'b1, 1'b0}, 1'b0, 17'd0},
        // empty column, then the table end
        '{ROW_CELL, 16'd0, '{16'd0, 16'd1, 16'd1, 1'b1, 1'b0}, 1'b0, 17'd0},
        '{ROW_CELL, 16'd0, '{16'd50, 16'd60, 16'd40, 1'b0, 1'b1}, 1'b0, 17'd0}
    };

    clustering_f_measure u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cell_count (i_cell_count),
        .i_row_total  (i_row_total),
        .i_col_total  (i_col_total),
        .i_column_end (i_column_end),
        .i_table_end  (i_table_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_f_measure  (o_f_measure)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("[clustering_f_measure] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        n_errors++;
        $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
    endtask

    // advance the f-measure accumulator by one cell; returns 1 on a table end
    function automatic bit fmeasure_step(input cell_req_t c, output logic [FRAC_W:0] fm);
        longint unsigned num, den, q, term, f;
        fm = '0;
        if (c.count != 0) begin
            num = c.count;
            num = num * 2;
            den = c.row;
            den = den + c.col;
            if (den != 0) begin
                if (num > den) num = den;
                // cross-multiplied compare, strictly greater replaces
                if (num * best_den > den * best_num) begin
                    best_num = num[CNT_W:0];
                    best_den = den[CNT_W:0];
                end
            end
        end
        if (c.col_end || c.tab_end) begin
            q = best_num;
            q = (q << FRAC_W) / best_den;
            if (q > FM_ONE) q = FM_ONE;
            term = q * c.col;
            if (term > SUM_SAT - weighted) weighted = SUM_SAT;
            else weighted = weighted + term;
            best_num = '0;
            best_den = 17'd1;
        end
        if (c.tab_end) begin
            f = 0;
            if (total_items != 0) f = weighted / total_items;
            if (f > FM_ONE) f = FM_ONE;
            fm = f[FRAC_W:0];
            weighted = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // offer one request, hold it until accepted, then predict
    task automatic offer_cell(input cell_req_t c, input bit typed, input logic [FRAC_W:0] typed_fm);
        logic [FRAC_W:0] fm;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_count <= c.count;
        i_row_total  <= c.row;
        i_col_total  <= c.col;
        i_column_end <= c.col_end;
        i_table_end  <= c.tab_end;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (fmeasure_step(c, fm)) fm_pending.push_back(typed ? typed_fm : fm);
        n_cells_sent++;
    endtask

    // wait for all pending results, then let the block go quiet
    task automatic settle();
        int unsigned waited;
        i_valid <= 1'b0;
        waited = 0;
        while (fm_pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (fm_pending.size() != 0) begin
            report_mismatch("results never arrived", fm_pending.size(), 0);
            fm_pending.delete();
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        total_items = value;
    endtask

    // well-formed contingency table, streamed column by column
    task automatic send_table(input int unsigned scale);
        logic [CNT_W-1:0] cells [4][4];
        int unsigned      row_sum [4];
        int unsigned      col_sum [4];
        int unsigned      n_rows, n_cols;
        cell_req_t        c;
        n_rows = $urandom_range(1, 4);
        n_cols = $urandom_range(1, 4);
        for (int r = 0; r < 4; r++) begin
            row_sum[r] = 0;
            col_sum[r] = 0;
        end
        for (int r = 0; r < n_rows; r++) begin
            for (int k = 0; k < n_cols; k++) begin
                cells[r][k] = ($urandom_range(99) < 30) ? '0
                            : CNT_W'($urandom_range(1, scale));
                row_sum[r] += cells[r][k];
                col_sum[k] += cells[r][k];
            end
        end
        for (int k = 0; k < n_cols; k++) begin
            for (int r = 0; r < n_rows; r++) begin
                c.count   = cells[r][k];
                c.row     = CNT_W'(row_sum[r]);
                c.col     = CNT_W'(col_sum[k]);
                c.tab_end = (k == n_cols - 1) && (r == n_rows - 1);
                c.col_end = c.tab_end ? 1'($urandom_range(1)) : (r == n_rows - 1);
                offer_cell(c, 1'b0, '0);
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off when armed
    always @(posedge i_clk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            i_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (fm_pending.size() == 0) begin
                report_mismatch("f_measure with nothing pending", o_f_measure, 0);
            end else begin
                want_fm = fm_pending.pop_front();
                if (o_f_measure !== want_fm) begin
                    report_mismatch("f_measure", o_f_measure, want_fm);
                end
            end
        end
    end

    // stimulus
    initial begin
        cell_req_t   c;
        int unsigned batch_stop;
        int unsigned scale;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_total(dir_rows[k].cfg_total);
            end else begin
                offer_cell(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].fm);
            end
        end

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            settle();
            tx_idle_pct <= tx_pct_by_phase[ph];
            rx_idle_pct <= rx_pct_by_phase[ph];
            @(posedge i_clk);
            batch_stop = n_cells_sent;
            for (int b = 0; b < BATCHES; b++) begin
                case (b)
                    0: write_total(16'hFFFF);
                    1: write_total(16'd1);
                    2: write_total(CNT_W'($urandom));
                    3: write_total(CNT_W'($urandom_range(1, 300)));
                    default: write_total(CNT_W'($urandom_range(1, 5000)));
                endcase
                if (ph == 2 && b == 0) hold_armed <= 1'b1;
                batch_stop += ITEMS_PER_PHASE / BATCHES;
                while (n_cells_sent < batch_stop) begin
                    if ($urandom_range(99) < 15) begin
                        // noise: unrelated cells, stray flags
                        repeat ($urandom_range(1, 5)) begin
                            c.count   = CNT_W'($urandom);
                            c.row     = CNT_W'($urandom);
                            c.col     = CNT_W'($urandom);
                            c.col_end = 1'($urandom_range(1));
                            c.tab_end = ($urandom_range(5) == 0);
                            offer_cell(c, 1'b0, '0);
                        end
                    end else begin
                        case ($urandom_range(3))
                            0: scale = 3;
                            1: scale = 40;
                            2: scale = 1000;
                            default: scale = 16383;
                        endcase
                        send_table(scale);
                    end
                end
            end
        end

        settle();
        if (n_errors == 0) begin
            $display("[clustering_f_measure] OK");
        end else begin
            $display("[clustering_f_measure] ERROR");
        end
        $finish;
    end

endmodule
